// File: hdl/rpwm_pkg.sv
// Shared types and constants for the three-channel LED PWM generator.
package rpwm_pkg;

  // Widths of the counter, duty and cutoff values.
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned DUTY_W = 8;
  localparam int unsigned NUM_CH = 3;

  // duty * period stays below 2^23, so floor(x / 100) = (x * RECIP_MUL) >> RECIP_SHIFT.
  localparam int unsigned PROD_W      = PCT_W + CNT_W;
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd10737419;
  localparam int unsigned QPROD_W     = PROD_W + RECIP_W;

  // Largest valid duty percent.
  localparam logic signed [DUTY_W-1:0] DUTY_MAX = 8'sd100;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] PERIOD_RST   = 16'd1249;
  localparam logic [PCT_W-1:0] OFF_BELOW_RST = 7'd5;
  localparam logic [PCT_W-1:0] ON_ABOVE_RST  = 7'd95;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PERIOD    = 2'd0,
    REG_OFF_BELOW = 2'd1,
    REG_ON_ABOVE  = 2'd2
  } reg_idx_t;

  // Item function codes.
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_SET  = 1'b1
  } func_t;

  // Channel drive modes.
  typedef enum logic [1:0] {
    MODE_PWM  = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2
  } mode_t;

endpackage

// File: hdl/rgb_pwm_percent_shadowed.sv
// Three-channel LED PWM generator with shared counter and shadowed compare values.
// An accepted item waits in the input register and moves into the result register,
// raising out_valid, once the result slot is free.
// Throughput: one item per cycle unless out_ready stalls; the input register and the
// result register form a two-stage pipeline, and the duty scaling uses one multiply per stage.
// Reset (rst_n low, synchronous) empties both stages, clears counter and channel
// state, selects PWM mode on all channels and loads the default configuration.
module rgb_pwm_percent_shadowed (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [1:0]                     in_channel,
  input  logic signed [rpwm_pkg::DUTY_W-1:0] in_duty,
  // Result item channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_led_red,
  output logic                           out_led_green,
  output logic                           out_led_blue,
  output logic                           out_duty_error,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);
  import rpwm_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] period_r;
  logic [PCT_W-1:0] off_below_r;
  logic [PCT_W-1:0] on_above_r;

  // Input stage registers.
  logic                     in_valid_r;
  func_t                    func_r;
  logic [1:0]               chan_r;
  logic signed [DUTY_W-1:0] duty_r;
  logic [PROD_W-1:0]        prod_r;

  // Channel and counter state.
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cmp_r [NUM_CH];
  logic [CNT_W-1:0]  cmp_nxt [NUM_CH];
  logic [CNT_W-1:0]  shadow_r [NUM_CH];
  logic [CNT_W-1:0]  shadow_nxt [NUM_CH];
  logic [NUM_CH-1:0] pend_r, pend_nxt;
  mode_t             mode_r [NUM_CH];
  mode_t             mode_nxt [NUM_CH];
  logic [NUM_CH-1:0] level_r, level_nxt;

  // Result stage registers.
  logic out_valid_r;
  logic err_r, err_nxt;

  logic              adv;
  logic [QPROD_W-1:0] qprod;
  logic [CNT_W-1:0]  quot;
  logic [PCT_W-1:0]  pct;
  logic              duty_bad;

  // Handshake: the item in the input register moves on when the result slot is free.
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_led_red    = level_r[0];
  assign out_led_green  = level_r[1];
  assign out_led_blue   = level_r[2];
  assign out_duty_error = err_r;

  // Scale duty * period by 1/100 through a reciprocal multiply.
  assign qprod = QPROD_W'(prod_r) * QPROD_W'(RECIP_MUL);
  assign quot  = qprod[RECIP_SHIFT +: CNT_W];
  assign pct   = duty_r[PCT_W-1:0];
  assign duty_bad = (duty_r < 0) || (duty_r > DUTY_MAX);

  // Next state of the counter and the channels for the item in the input register.
  always_comb begin
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    level_nxt = level_r;
    err_nxt   = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      cmp_nxt[c]    = cmp_r[c];
      shadow_nxt[c] = shadow_r[c];
      mode_nxt[c]   = mode_r[c];
    end
    if (func_r == FUNC_TICK) begin
      cnt_nxt = (cnt_r >= period_r) ? '0 : cnt_r + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        if (mode_r[c] == MODE_PWM) begin
          if (cnt_nxt == cmp_r[c]) begin
            level_nxt[c] = 1'b0;
            if (pend_r[c]) begin
              cmp_nxt[c]  = shadow_r[c];
              pend_nxt[c] = 1'b0;
            end
          end
          if (cnt_nxt == period_r) begin
            level_nxt[c] = 1'b1;
          end
        end
      end
    end else if (duty_bad) begin
      err_nxt = 1'b1;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (chan_r == 2'(c)) begin
          priority if (pct < off_below_r) begin
            mode_nxt[c]  = MODE_LOW;
            level_nxt[c] = 1'b0;
            pend_nxt[c]  = 1'b0;
          end else if (pct > on_above_r) begin
            mode_nxt[c]  = MODE_HIGH;
            level_nxt[c] = 1'b1;
            pend_nxt[c]  = 1'b0;
          end else begin
            mode_nxt[c]   = MODE_PWM;
            shadow_nxt[c] = quot;
            pend_nxt[c]   = 1'b1;
          end
        end
      end
    end
  end

  // Control state, configuration and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      off_below_r <= OFF_BELOW_RST;
      on_above_r  <= ON_ABOVE_RST;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= '0;
      level_r     <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        cmp_r[c]    <= '0;
        shadow_r[c] <= '0;
        mode_r[c]   <= MODE_PWM;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PERIOD:    period_r    <= cfg_data;
          REG_OFF_BELOW: off_below_r <= cfg_data[PCT_W-1:0];
          REG_ON_ABOVE:  on_above_r  <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        err_r       <= err_nxt;
        cnt_r       <= cnt_nxt;
        pend_r      <= pend_nxt;
        level_r     <= level_nxt;
        for (int c = 0; c < NUM_CH; c++) begin
          cmp_r[c]    <= cmp_nxt[c];
          shadow_r[c] <= shadow_nxt[c];
          mode_r[c]   <= mode_nxt[c];
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input payload capture; the duty product is formed on the way in.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= func_t'(in_func);
      chan_r <= in_channel;
      duty_r <= in_duty;
      prod_r <= PROD_W'(in_duty[PCT_W-1:0]) * PROD_W'(period_r);
    end
  end

  // A forced channel holds its level and never carries a pending update.
  for (genvar g = 0; g < NUM_CH; g++) begin : g_chk
    assert property (@(posedge clk) disable iff (!rst_n)
      (mode_r[g] == MODE_LOW) |-> !level_r[g])
      else $error("forced-low channel drives high");
    assert property (@(posedge clk) disable iff (!rst_n)
      (mode_r[g] == MODE_HIGH) |-> level_r[g])
      else $error("forced-high channel drives low");
    assert property (@(posedge clk) disable iff (!rst_n)
      pend_r[g] |-> (mode_r[g] == MODE_PWM))
      else $error("pending update outside PWM mode");
  end

  // The counter only moves when an item is processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cnt_r))
    else $error("counter moved without an item");

  // A rejected duty leaves the channel levels untouched.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && err_nxt) |=> $stable(level_r) && $stable(pend_r))
    else $error("rejected duty changed channel state");

endmodule

// File: test/tb_rgb_pwm_percent_shadowed.sv
// Self-checking testbench for the three-channel LED PWM generator with shadowed compare values.
module tb_rgb_pwm_percent_shadowed;
  import rpwm_pkg::*;

  // One result item: the three LED levels and the duty error flag.
  typedef struct {
    logic red;
    logic green;
    logic blue;
    logic err;
  } led_levels_t;

  // Tracks the counter and channel state and holds the LED levels still to come.
  class led_level_scoreboard;
    logic [CNT_W-1:0] period;
    logic [PCT_W-1:0] off_below;
    logic [PCT_W-1:0] on_above;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] compare [NUM_CH];
    logic [CNT_W-1:0] shadow [NUM_CH];
    bit               reload [NUM_CH];
    mode_t            mode [NUM_CH];
    bit               level [NUM_CH];
    led_levels_t      expected_levels [$];
    int errors;
    int items;
    int duty_writes;
    int rejected;
    int reloads;
    int results;

    function new();
      period    = PERIOD_RST;
      off_below = OFF_BELOW_RST;
      on_above  = ON_ABOVE_RST;
      count     = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        compare[c] = '0;
        shadow[c]  = '0;
        reload[c]  = 1'b0;
        mode[c]    = MODE_PWM;
        level[c]   = 1'b0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_PERIOD:    period = data;
        REG_OFF_BELOW: off_below = data[PCT_W-1:0];
        REG_ON_ABOVE:  on_above = data[PCT_W-1:0];
        default: ;
      endcase
    endfunction

    // One tick: step or wrap the counter, then apply compare and period events.
    function void advance_count();
      if (count >= period) begin
        count = '0;
      end else begin
        count = count + 1'b1;
      end
      for (int c = 0; c < NUM_CH; c++) begin
        if (mode[c] == MODE_PWM) begin
          // The low event comes first, so a compare at the period still ends high.
          if (count == compare[c]) begin
            level[c] = 1'b0;
            if (reload[c]) begin
              compare[c] = shadow[c];
              reload[c]  = 1'b0;
              reloads++;
            end
          end
          if (count == period) begin
            level[c] = 1'b1;
          end
        end
      end
    endfunction

    // A valid percent: forced low, forced high, or a new shadow compare value.
    function void apply_duty(int ch, int pct);
      if (ch >= NUM_CH) begin
        return;
      end
      if (pct < int'(off_below)) begin
        mode[ch]   = MODE_LOW;
        level[ch]  = 1'b0;
        reload[ch] = 1'b0;
      end else if (pct > int'(on_above)) begin
        mode[ch]   = MODE_HIGH;
        level[ch]  = 1'b1;
        reload[ch] = 1'b0;
      end else begin
        mode[ch]   = MODE_PWM;
        shadow[ch] = CNT_W'((pct * int'(period)) / 100);
        reload[ch] = 1'b1;
      end
    endfunction

    function void note_item(func_t func, logic [1:0] ch, logic signed [DUTY_W-1:0] duty);
      int pct;
      led_levels_t lv;
      pct    = int'(duty);
      lv.err = 1'b0;
      items++;
      if (func == FUNC_TICK) begin
        advance_count();
      end else if (pct < 0 || pct > int'(DUTY_MAX)) begin
        lv.err = 1'b1;
        rejected++;
      end else begin
        duty_writes++;
        apply_duty(int'(ch), pct);
      end
      lv.red   = level[0];
      lv.green = level[1];
      lv.blue  = level[2];
      expected_levels.push_back(lv);
    endfunction

    function void check_field(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic red, logic green, logic blue, logic err);
      led_levels_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: result with no item waiting, actual red %0b green %0b blue %0b error %0b",
                 $time, red, green, blue, err);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      results++;
      check_field("led_red", want.red, red);
      check_field("led_green", want.green, green);
      check_field("led_blue", want.blue, blue);
      check_field("duty_error", want.err, err);
    endfunction

    function int pending_count();
      return expected_levels.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 190;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_func = FUNC_TICK;
  logic [1:0]               in_channel = 2'd0;
  logic signed [DUTY_W-1:0] in_duty = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_led_red;
  logic                     out_led_green;
  logic                     out_led_blue;
  logic                     out_duty_error;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = REG_PERIOD;
  logic [15:0]              cfg_data = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cfg_writes = 0;
  int stall_cycles = 0;

  // Register settings of the random phases; the last phase draws its own.
  logic [15:0] period_plan [PHASES-1] = '{16'd20, 16'd1, 16'd0, 16'd65535, 16'd7};
  logic [15:0] off_plan [PHASES-1]    = '{16'd5, 16'd0, 16'd100, 16'd10, 16'd60};
  logic [15:0] on_plan [PHASES-1]     = '{16'd95, 16'd100, 16'd0, 16'd90, 16'd40};

  led_level_scoreboard sb = new();

  rgb_pwm_percent_shadowed u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_channel     (in_channel),
    .in_duty        (in_duty),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_red    (out_led_red),
    .out_led_green  (out_led_green),
    .out_led_blue   (out_led_blue),
    .out_duty_error (out_duty_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random at the current rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every accepted result against the oldest expected levels.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_led_red, out_led_green, out_led_blue, out_duty_error);
    end
  end

  // End the run when nothing has been accepted on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, sb.pending_count());
      $display("tb_rgb_pwm_percent_shadowed: errors");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic push_pwm_item(func_t func, logic [1:0] ch, logic signed [DUTY_W-1:0] duty);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_channel <= ch;
    in_duty    <= duty;
    do @(posedge clk); while (!in_ready);
    sb.note_item(func, ch, duty);
  endtask

  // Stop offering items and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [15:0] data);
    repeat (2) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Mostly ticks so the counter runs through whole periods; duty writes lean
  // toward valid percents and the cutoff boundaries.
  task automatic drive_random_item();
    int pick;
    logic [1:0] ch;
    logic signed [DUTY_W-1:0] duty;
    pick = $urandom_range(99);
    if (pick < 68) begin
      push_pwm_item(FUNC_TICK, 2'($urandom_range(3)), DUTY_W'($urandom));
    end else begin
      ch   = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      pick = $urandom_range(99);
      if (pick < 55) begin
        duty = DUTY_W'($urandom_range(100));
      end else if (pick < 80) begin
        case ($urandom_range(5))
          0: duty = '0;
          1: duty = DUTY_MAX;
          2: duty = DUTY_W'(int'(sb.off_below) - 1);
          3: duty = DUTY_W'(sb.off_below);
          4: duty = DUTY_W'(sb.on_above);
          default: duty = DUTY_W'(int'(sb.on_above) + 1);
        endcase
      end else begin
        duty = DUTY_W'($urandom);
      end
      push_pwm_item(FUNC_SET, ch, duty);
    end
  endtask

  initial begin
    logic [15:0] per;
    logic [15:0] off;
    logic [15:0] on;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    tx_idle_pct = 13;
    rx_idle_pct = 74;

    // Reset configuration: a tick, a valid percent, out-of-range percents and the unused fourth channel.
    push_pwm_item(FUNC_TICK, 2'd0, 8'sd0);
    push_pwm_item(FUNC_SET, 2'd0, 8'sd50);
    push_pwm_item(FUNC_SET, 2'd1, -8'sd128);
    push_pwm_item(FUNC_SET, 2'd2, 8'sd127);
    push_pwm_item(FUNC_SET, 2'd1, 8'sd101);
    push_pwm_item(FUNC_SET, 2'd0, -8'sd1);
    push_pwm_item(FUNC_SET, 2'd3, 8'sd50);
    push_pwm_item(FUNC_SET, 2'd3, -8'sd7);

    // Short period: forced modes, leaving them, and a full counter period with a wrap.
    drain_results();
    write_cfg(REG_PERIOD, 16'd9);
    push_pwm_item(FUNC_SET, 2'd0, 8'sd4);
    push_pwm_item(FUNC_SET, 2'd0, 8'sd5);
    push_pwm_item(FUNC_SET, 2'd1, 8'sd96);
    push_pwm_item(FUNC_SET, 2'd1, 8'sd95);
    push_pwm_item(FUNC_SET, 2'd2, 8'sd0);
    push_pwm_item(FUNC_SET, 2'd2, 8'sd100);
    repeat (10) push_pwm_item(FUNC_TICK, 2'd0, 8'sd0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == 2) begin
        tx_idle_pct = 74;
        rx_idle_pct = 13;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p < PHASES - 1) begin
        per = period_plan[p];
        off = off_plan[p];
        on  = on_plan[p];
      end else begin
        per = 16'($urandom_range(30, 2));
        off = 16'($urandom_range(100));
        on  = 16'($urandom_range(100));
      end
      write_cfg(REG_PERIOD, per);
      write_cfg(REG_OFF_BELOW, off);
      write_cfg(REG_ON_ABOVE, on);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Let the pipeline run dry once in the middle of a phase.
        if (p == 2 && i == PHASE_ITEMS / 2) begin
          drain_results();
        end
        drive_random_item();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d items (%0d duty writes, %0d rejected percents, %0d compare reloads)",
             sb.items, sb.duty_writes, sb.rejected, sb.reloads);
    $display("under %0d register writes; %0d results checked, %0d mismatches.",
             cfg_writes, sb.results, sb.errors);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("tb_rgb_pwm_percent_shadowed: clean");
    end else begin
      $display("tb_rgb_pwm_percent_shadowed: errors");
    end
    $finish;
  end

endmodule
